@@ sv/acm_pkg.sv @@
// types, constants and saturation helper for the assignment constraint operator
package acm_pkg;

  localparam int VAL_W  = 32;
  localparam int ACC_W  = 38;
  localparam int CALC_W = 9;
  localparam int CNT_W  = 4;

  localparam logic [1:0] CMD_WR_SCALE   = 2'd0;
  localparam logic [1:0] CMD_WR_OPERAND = 2'd1;
  localparam logic [1:0] CMD_RD_FWD     = 2'd2;
  localparam logic [1:0] CMD_RD_ADJ     = 2'd3;

  localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [6:0]        index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               index_error;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic add;
    logic neg;
    logic scl;
    logic last;
  } rd_tag_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } clip_t;

  function automatic clip_t sat32(input logic signed [63:0] v);
    clip_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > Q_MAX) begin
      r.sat = 1'b1;
      r.val = Q_MAX[31:0];
    end else if (v < Q_MIN) begin
      r.sat = 1'b1;
      r.val = Q_MIN[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/assignment_constraint_matvec_core.sv @@
// Scaled constraint operator of a users-by-messages assignment problem. Every item
// (write scale entry, write operand entry, forward read, adjoint read) gives one
// result on result, marked by done for a single cycle; the receiver cannot stall,
// so the result must be taken in that cycle. Scale and operand entries live in two
// single-port memories with registered reads that are read side by side. A write or
// any index error gives its result in the cycle after it is taken. A forward read of
// element e first finds its row index in a subtract-per-cycle divider, then four
// entries are read, multiplied and summed through a three-stage
// read/multiply/accumulate pipe. An adjoint read of a user row, a message column
// or a single entry makes one memory read per summed entry, one more for the scale,
// and a final scaling multiply. A new item can be taken in the cycle in which done
// is high. The stores are undefined until written.
module assignment_constraint_matvec_core #(
  parameter int MAX_USERS    = 8,
  parameter int MAX_MESSAGES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  acm_pkg::in_item_t  item,
  output logic               done,
  output acm_pkg::out_item_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH = MAX_USERS + 2 * MAX_MESSAGES + MAX_USERS * MAX_MESSAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [3:0] USER_RST = (MAX_USERS < 8) ? 4'(MAX_USERS) : 4'd8;
  localparam logic [3:0] MSG_RST  = (MAX_MESSAGES < 8) ? 4'(MAX_MESSAGES) : 4'd8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  function automatic logic [3:0] clamp_cnt(input logic [3:0] v, input int maxv);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (int'(v) > maxv) begin
      r = 4'(maxv);
    end
    return r;
  endfunction

  // configuration
  logic [3:0] user_count;
  logic [3:0] message_count;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[2] ? {28'd0, message_count} : {28'd0, user_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      user_count    <= USER_RST;
      message_count <= MSG_RST;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        message_count <= clamp_cnt(pwdata[3:0], MAX_MESSAGES);
      end else begin
        user_count <= clamp_cnt(pwdata[3:0], MAX_USERS);
      end
    end
  end

  // sizes in use
  logic [acm_pkg::CALC_W-1:0] u9, m9, len, cells, idx9;
  assign u9    = acm_pkg::CALC_W'(user_count);
  assign m9    = acm_pkg::CALC_W'(message_count);
  assign len   = u9 + (m9 << 1) + u9 * m9;
  assign cells = u9 * m9;
  assign idx9  = acm_pkg::CALC_W'(item.index);

  // control state
  logic [2:0] state;
  logic       accept;
  logic       fwd;
  logic [6:0] idx;
  logic [6:0] rem;
  logic [3:0] qi;
  logic [3:0] ctr;
  logic [3:0] n_ops;
  logic       adj_neg;
  logic [acm_pkg::CALC_W-1:0] run_addr;
  logic [acm_pkg::CALC_W-1:0] run_step;

  assign busy   = (state != S_IDLE);
  assign accept = start & ~busy;

  logic wr_err, fwd_err, adj_err, item_err;
  assign wr_err   = (idx9 >= len);
  assign fwd_err  = (idx9 >= cells);
  assign adj_err  = (idx9 >= len);

  always_comb begin
    unique case (item.cmd)
      acm_pkg::CMD_WR_SCALE,
      acm_pkg::CMD_WR_OPERAND: item_err = wr_err;
      acm_pkg::CMD_RD_FWD:     item_err = fwd_err;
      default:                 item_err = adj_err;
    endcase
  end

  logic is_wr;
  assign is_wr = (item.cmd == acm_pkg::CMD_WR_SCALE) || (item.cmd == acm_pkg::CMD_WR_OPERAND);

  // adjoint walk setup
  logic [acm_pkg::CALC_W-1:0] adj_base;
  logic [acm_pkg::CALC_W-1:0] adj_step;
  logic [3:0]                 adj_n;
  logic                       adj_ng;

  always_comb begin
    priority if (idx9 < u9) begin
      // a user row is contiguous
      adj_base = idx9 * m9;
      adj_step = acm_pkg::CALC_W'(1);
      adj_n    = message_count;
      adj_ng   = 1'b0;
    end else if (idx9 < u9 + m9) begin
      adj_base = idx9 - u9;
      adj_step = m9;
      adj_n    = user_count;
      adj_ng   = 1'b1;
    end else if (idx9 < u9 + (m9 << 1)) begin
      adj_base = idx9 - u9 - m9;
      adj_step = m9;
      adj_n    = user_count;
      adj_ng   = 1'b0;
    end else begin
      adj_base = idx9 - u9 - (m9 << 1);
      adj_step = m9;
      adj_n    = 4'd1;
      adj_ng   = 1'b1;
    end
  end

  // read issue
  logic                       rd_en;
  logic [acm_pkg::CALC_W-1:0] rd_calc;
  acm_pkg::rd_tag_t           tag0, tag1, tag2;
  logic                       issue_last;

  always_comb begin
    tag0    = '0;
    rd_calc = run_addr;
    rd_en   = (state == S_ISSUE);
    if (fwd) begin
      unique case (ctr[1:0])
        2'd0:    rd_calc = acm_pkg::CALC_W'(qi);
        2'd1:    rd_calc = u9 + acm_pkg::CALC_W'(rem);
        2'd2:    rd_calc = u9 + m9 + acm_pkg::CALC_W'(rem);
        default: rd_calc = u9 + (m9 << 1) + acm_pkg::CALC_W'(idx);
      endcase
      tag0.add  = 1'b1;
      tag0.neg  = ctr[0];
      tag0.last = (ctr == 4'd3);
    end else if (ctr == n_ops) begin
      rd_calc   = acm_pkg::CALC_W'(idx);
      tag0.scl  = 1'b1;
      tag0.last = 1'b1;
    end else begin
      tag0.add = 1'b1;
      tag0.neg = adj_neg;
    end
  end
  assign issue_last = tag0.last;

  // stores
  logic [31:0] scale_mem   [DEPTH];
  logic [31:0] operand_mem [DEPTH];
  logic [31:0] scale_rd, op_rd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_scale, wr_operand;

  assign rd_addr    = AW'(rd_calc);
  assign wr_addr    = AW'(item.index);
  assign wr_scale   = accept && (item.cmd == acm_pkg::CMD_WR_SCALE) && !wr_err;
  assign wr_operand = accept && (item.cmd == acm_pkg::CMD_WR_OPERAND) && !wr_err;

  always_ff @(posedge clk) begin
    if (wr_scale) begin
      scale_mem[wr_addr] <= item.value;
    end
    if (rd_en) begin
      scale_rd <= scale_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_operand) begin
      operand_mem[wr_addr] <= item.value;
    end
    if (rd_en) begin
      op_rd <= operand_mem[rd_addr];
    end
  end

  // multiply stage, shared with the final adjoint scaling
  logic signed [31:0]            mul_a, mul_b, scale_hold;
  logic signed [63:0]            prod;
  logic signed [acm_pkg::ACC_W-1:0] acc;
  logic                          sat;
  acm_pkg::clip_t                term, acc_c;
  logic signed [acm_pkg::ACC_W-1:0] term_x;

  always_comb begin
    if (state == S_FIN) begin
      mul_a = acc_c.val;
      mul_b = scale_hold;
    end else begin
      mul_a = $signed(op_rd);
      mul_b = fwd ? $signed(scale_rd) : acm_pkg::Q_ONE;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (tag1.scl) begin
      scale_hold <= $signed(scale_rd);
    end
  end

  assign term   = acm_pkg::sat32(prod >>> 16);
  assign acc_c  = acm_pkg::sat32($signed({{(64 - acm_pkg::ACC_W){acc[acm_pkg::ACC_W-1]}}, acc}));
  assign term_x = $signed({{(acm_pkg::ACC_W - 32){term.val[31]}}, term.val});

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag1 <= rd_en ? tag0 : '0;
      tag2 <= tag1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx      <= item.index;
            fwd      <= (item.cmd == acm_pkg::CMD_RD_FWD);
            rem      <= item.index;
            qi       <= '0;
            ctr      <= '0;
            n_ops    <= adj_n;
            adj_neg  <= adj_ng;
            run_addr <= adj_base;
            run_step <= adj_step;
            acc      <= '0;
            sat      <= 1'b0;
            if (is_wr || item_err) begin
              done                <= 1'b1;
              result.result_value <= '0;
              result.index_error  <= item_err;
              result.saturated    <= 1'b0;
            end else if (item.cmd == acm_pkg::CMD_RD_FWD) begin
              state <= S_DIV;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_DIV: begin
          // row index by repeated subtraction
          if (rem >= 7'(message_count)) begin
            rem <= rem - 7'(message_count);
            qi  <= qi + 4'd1;
          end else begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          ctr      <= ctr + 4'd1;
          run_addr <= run_addr + run_step;
          if (issue_last) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (tag2.last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fwd) begin
            done                <= 1'b1;
            result.result_value <= acc_c.val;
            result.index_error  <= 1'b0;
            result.saturated    <= sat | acc_c.sat;
            state               <= S_IDLE;
          end else begin
            sat   <= sat | acc_c.sat;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          done                <= 1'b1;
          result.result_value <= term.val;
          result.index_error  <= 1'b0;
          result.saturated    <= sat | term.sat;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // accumulate stage of the read pipe
      if (tag2.add) begin
        acc <= tag2.neg ? acc - term_x : acc + term_x;
        sat <= sat | term.sat;
      end
    end
  end

endmodule
